// ===== sv/abbc_pkg.sv =====
// Package for the ABBA/BABA block counter: widths, base and command codes,
// the sequencer state type, shared structs and the transversion function.
// No dependencies.
`default_nettype none

package abbc_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int POSITION_BITS = 32;
  localparam int BLOCK_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam int OUT_BITS      = 32;
  localparam int BASE_BITS     = 3;

  // Divider widths cover both the ratio and the position remainder.
  localparam int DIV_A         = COUNT_BITS + FRAC_BITS;
  localparam int DIV_B         = (POSITION_BITS > DIV_A) ? POSITION_BITS : DIV_A;
  localparam int DIV_BITS      = (DIV_B > OUT_BITS + 1) ? DIV_B : OUT_BITS + 1;
  localparam int DVS_BITS      = (COUNT_BITS > BLOCK_BITS) ? COUNT_BITS : BLOCK_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

  localparam logic [BLOCK_BITS-1:0] BLOCK_LEN_RESET = BLOCK_BITS'(1000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [BASE_BITS-1:0] BASE_A = 3'd0;
  localparam logic [BASE_BITS-1:0] BASE_C = 3'd1;
  localparam logic [BASE_BITS-1:0] BASE_G = 3'd2;
  localparam logic [BASE_BITS-1:0] BASE_T = 3'd3;
  localparam logic [BASE_BITS-1:0] BASE_N = 3'd4;

  localparam logic CMD_COLUMN = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RATIO_START,
    S_RATIO_WAIT,
    S_FINISH,
    S_REM_START,
    S_REM_WAIT
  } state_t;

  typedef struct packed {
    logic abba_one;
    logic baba_one;
    logic abba_two;
    logic baba_two;
  } site_hits_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // A transversion pairs a purine with a pyrimidine; unknown codes never do.
  function automatic logic transversion(input logic [BASE_BITS-1:0] x,
                                        input logic [BASE_BITS-1:0] y);
    logic [BASE_BITS-1:0] d;
    d = x ^ y;
    return (x <= BASE_T) && (y <= BASE_T) && (d inside {3'd1, 3'd3});
  endfunction

endpackage

`default_nettype wire

// ===== sv/abbc_site_match.sv =====
// Site pattern detector: tests one alignment column for the four
// ABBA/BABA patterns. Depends on abbc_pkg.
`default_nettype none

module abbc_site_match
  import abbc_pkg::*;
(
  input  logic [BASE_BITS-1:0] base_first,
  input  logic [BASE_BITS-1:0] base_second,
  input  logic [BASE_BITS-1:0] base_admix,
  input  logic [BASE_BITS-1:0] base_admix_two,
  input  logic [BASE_BITS-1:0] base_outgroup,
  output site_hits_t           hits
);

  logic no_n;
  logic tv_second;
  logic tv_admix;

  assign no_n = (base_first != BASE_N) && (base_second != BASE_N) &&
                (base_admix != BASE_N) && (base_admix_two != BASE_N) &&
                (base_outgroup != BASE_N);

  assign tv_second = transversion(base_first, base_second);
  assign tv_admix  = transversion(base_first, base_admix);

  always_comb begin
    hits.abba_one = no_n && tv_second && (base_first == base_outgroup) &&
                    (base_second != base_outgroup) && (base_second == base_admix_two);
    hits.baba_one = no_n && tv_second && (base_first != base_outgroup) &&
                    (base_second == base_outgroup) && (base_first == base_admix_two);
    hits.abba_two = no_n && tv_admix && (base_first == base_outgroup) &&
                    (base_admix != base_outgroup) && (base_admix == base_admix_two);
    hits.baba_two = no_n && tv_admix && (base_first == base_admix_two) &&
                    (base_admix_two != base_outgroup) && (base_admix == base_outgroup);
  end

endmodule

`default_nettype wire

// ===== sv/abbc_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the ratio and
// the position remainder. Depends on abbc_pkg.
`default_nettype none

module abbc_divider
  import abbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic [DIV_BITS-1:0] quotient,
  output logic [DVS_BITS-1:0] remainder,
  output div_status_t         status
);

  logic [DIV_BITS-1:0]     quot;
  logic [DVS_BITS-1:0]     rem;
  logic [DVS_BITS-1:0]     dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic                    active;
  logic                    done;
  logic [DVS_BITS:0]       trial;
  logic [DVS_BITS:0]       diff;
  logic                    qbit;

  assign trial = {rem, quot[DIV_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_BITS'(DIV_BITS);
      end else if (active) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (active) begin
      quot <= {quot[DIV_BITS-2:0], qbit};
      rem  <= qbit ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
    end
  end

  assign quotient    = quot;
  assign remainder   = rem;
  assign status.busy = active;
  assign status.done = done;

endmodule

`default_nettype wire

// ===== sv/abba_baba_block_counter.sv =====
// ABBA/BABA block counter. A column that closes no block does not stall the
// input unless a block length write is pending; a block or scaffold end stalls
// it through start, the 40-step shared divider and finish (no division with a
// zero divisor), plus any output stall. A block length write stalls input to redo
// position mod block length (no division if zero). Synchronous reset clears counts
// and position and sets the block length to 1000.
`default_nettype none

module abba_baba_block_counter
  import abbc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BLOCK_BITS-1:0]  block_len,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [BASE_BITS-1:0]   base_first,
  input  logic [BASE_BITS-1:0]   base_second,
  input  logic [BASE_BITS-1:0]   base_admix,
  input  logic [BASE_BITS-1:0]   base_admix_two,
  input  logic [BASE_BITS-1:0]   base_outgroup,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [31:0]            end_position,
  output logic signed [31:0]     f_hat,
  output logic [23:0]            abba_one,
  output logic [23:0]            baba_one,
  output logic [23:0]            abba_two,
  output logic [23:0]            baba_two,
  output logic                   zero_divisor
);

  state_t state, state_next;

  logic [BLOCK_BITS-1:0]    blk_size;
  logic [POSITION_BITS-1:0] position;
  logic [BLOCK_BITS-1:0]    rem;
  logic [COUNT_BITS-1:0]    abba_one_count;
  logic [COUNT_BITS-1:0]    baba_one_count;
  logic [COUNT_BITS-1:0]    abba_two_count;
  logic [COUNT_BITS-1:0]    baba_two_count;
  logic                     flush_pend;
  logic                     zdiv;
  logic                     neg;

  site_hits_t               hits;
  div_status_t              div_stat;
  logic                     div_start;
  logic [DIV_BITS-1:0]      div_dividend;
  logic [DVS_BITS-1:0]      div_divisor;
  logic [DIV_BITS-1:0]      div_quot;
  logic [DVS_BITS-1:0]      div_rem;

  logic                     in_accept;
  logic                     cfg_accept;
  logic                     out_free;
  logic                     load_out;
  logic [POSITION_BITS-1:0] position_next;
  logic [BLOCK_BITS:0]      rem_inc;
  logic                     col_emit;
  logic                     den_zero;
  logic                     num_neg;
  logic                     den_neg;
  logic [COUNT_BITS-1:0]    num_mag;
  logic [COUNT_BITS-1:0]    den_mag;
  logic [DIV_BITS-1:0]      sat_lim;
  logic [DIV_BITS-1:0]      q_sat;
  logic [31:0]              q32;
  logic [31:0]              fixed;

  abbc_site_match u_match (
    .base_first     (base_first),
    .base_second    (base_second),
    .base_admix     (base_admix),
    .base_admix_two (base_admix_two),
    .base_outgroup  (base_outgroup),
    .hits           (hits)
  );

  abbc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .status    (div_stat)
  );

  assign in_accept  = in_valid && !in_stall;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !out_valid || !out_stall;

  // The remainder register tracks position mod the block length; a wrap of
  // the position to zero is also a block boundary.
  assign position_next = position + POSITION_BITS'(1);
  assign rem_inc       = {1'b0, rem} + (BLOCK_BITS + 1)'(1);
  assign col_emit      = (blk_size != '0) &&
                         ((position_next == '0) || (rem_inc == {1'b0, blk_size}));

  assign den_zero = (abba_two_count == baba_two_count);
  assign num_neg  = (abba_one_count < baba_one_count);
  assign den_neg  = (abba_two_count < baba_two_count);
  assign num_mag  = num_neg ? (baba_one_count - abba_one_count)
                            : (abba_one_count - baba_one_count);
  assign den_mag  = den_neg ? (baba_two_count - abba_two_count)
                            : (abba_two_count - baba_two_count);

  always_comb begin
    if (state == S_REM_START) begin
      div_dividend = DIV_BITS'(position);
      div_divisor  = DVS_BITS'(blk_size);
    end else begin
      div_dividend = DIV_BITS'({num_mag, {FRAC_BITS{1'b0}}});
      div_divisor  = DVS_BITS'(den_mag);
    end
  end

  always_comb begin
    sat_lim = neg ? DIV_BITS'(64'h8000_0000) : DIV_BITS'(64'h7FFF_FFFF);
    q_sat   = (div_quot > sat_lim) ? sat_lim : div_quot;
    q32     = q_sat[31:0];
    fixed   = zdiv ? 32'd0 : (neg ? (~q32 + 32'd1) : q32);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cfg_accept) begin
          state_next = S_REM_START;
        end else if (in_accept && ((cmd == CMD_FLUSH) || col_emit)) begin
          state_next = S_RATIO_START;
        end
      end
      S_RATIO_START: state_next = den_zero ? S_FINISH : S_RATIO_WAIT;
      S_RATIO_WAIT:  if (div_stat.done) state_next = S_FINISH;
      S_FINISH:      if (out_free) state_next = S_IDLE;
      S_REM_START:   state_next = (blk_size == '0) ? S_IDLE : S_REM_WAIT;
      S_REM_WAIT:    if (div_stat.done) state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cfg_ready = 1'b0;
    in_stall  = 1'b1;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
      end
      S_RATIO_START: div_start = !den_zero;
      S_REM_START:   div_start = (blk_size != '0);
      S_FINISH:      load_out  = out_free;
      default: begin
        cfg_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      blk_size       <= BLOCK_LEN_RESET;
      position       <= '0;
      rem            <= '0;
      abba_one_count <= '0;
      baba_one_count <= '0;
      abba_two_count <= '0;
      baba_two_count <= '0;
      flush_pend     <= 1'b0;
      zdiv           <= 1'b0;
      neg            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && !load_out) begin
        out_valid <= 1'b0;
      end
      if (cfg_accept) begin
        blk_size <= block_len;
      end
      if (in_accept) begin
        if (cmd == CMD_FLUSH) begin
          flush_pend <= 1'b1;
        end else begin
          position <= position_next;
          rem      <= col_emit ? '0 : rem_inc[BLOCK_BITS-1:0];
          if (hits.abba_one && abba_one_count != COUNT_MAX) begin
            abba_one_count <= abba_one_count + COUNT_BITS'(1);
          end
          if (hits.baba_one && baba_one_count != COUNT_MAX) begin
            baba_one_count <= baba_one_count + COUNT_BITS'(1);
          end
          if (hits.abba_two && abba_two_count != COUNT_MAX) begin
            abba_two_count <= abba_two_count + COUNT_BITS'(1);
          end
          if (hits.baba_two && baba_two_count != COUNT_MAX) begin
            baba_two_count <= baba_two_count + COUNT_BITS'(1);
          end
        end
      end
      if (state == S_RATIO_START) begin
        zdiv <= den_zero;
        neg  <= num_neg ^ den_neg;
      end
      if (state == S_REM_START && blk_size == '0) begin
        rem <= '0;
      end
      if (state == S_REM_WAIT && div_stat.done) begin
        rem <= div_rem[BLOCK_BITS-1:0];
      end
      if (load_out) begin
        out_valid      <= 1'b1;
        abba_one_count <= '0;
        baba_one_count <= '0;
        abba_two_count <= '0;
        baba_two_count <= '0;
        flush_pend     <= 1'b0;
        if (flush_pend) begin
          position <= '0;
          rem      <= '0;
        end
      end
    end
  end

  // Output payload; counts are cleared only after this capture.
  always_ff @(posedge clk) begin
    if (load_out) begin
      end_position <= 32'(position);
      f_hat        <= fixed;
      abba_one     <= 24'(abba_one_count);
      baba_one     <= 24'(baba_one_count);
      abba_two     <= 24'(abba_two_count);
      baba_two     <= 24'(baba_two_count);
      zero_divisor <= zdiv;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_RATIO_WAIT || state == S_REM_WAIT))
    else $error("divider finished outside a wait state");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && blk_size != '0) |-> (rem < blk_size))
    else $error("position remainder out of range");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result shown without a finish step");

endmodule

`default_nettype wire

// ===== tb/abbc_row_checker.sv =====
// Checker for the ABBA/BABA block counter: watches the config, column and row
// channels, predicts every block row and compares it with what comes out.
// Depends on abbc_pkg for widths and codes.

module abbc_row_checker
  import abbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [BLOCK_BITS-1:0] block_len,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  cmd,
  input  logic [BASE_BITS-1:0]  base_first,
  input  logic [BASE_BITS-1:0]  base_second,
  input  logic [BASE_BITS-1:0]  base_admix,
  input  logic [BASE_BITS-1:0]  base_admix_two,
  input  logic [BASE_BITS-1:0]  base_outgroup,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [31:0]           end_position,
  input  logic signed [31:0]    f_hat,
  input  logic [23:0]           abba_one,
  input  logic [23:0]           baba_one,
  input  logic [23:0]           abba_two,
  input  logic [23:0]           baba_two,
  input  logic                  zero_divisor,
  output int                    errors,
  output int                    rows_waiting
);

  typedef struct packed {
    logic [31:0] end_position;
    logic [31:0] f_hat;
    logic [23:0] abba_one;
    logic [23:0] baba_one;
    logic [23:0] abba_two;
    logic [23:0] baba_two;
    logic        zero_divisor;
  } block_row_t;

  localparam longint RATIO_POS_LIMIT = 64'sh7FFF_FFFF;
  localparam longint RATIO_NEG_LIMIT = 64'sh8000_0000;

  block_row_t               expected_rows[$];
  logic [BLOCK_BITS-1:0]    cur_block_len;
  logic [POSITION_BITS-1:0] column_pos;
  logic [COUNT_BITS-1:0]    abba_one_n, baba_one_n, abba_two_n, baba_two_n;
  int                       mismatch_cnt = 0;

  // Purines are A and G, pyrimidines C and T: the low bit of the code tells
  // them apart.
  function automatic logic crosses_ring(input logic [BASE_BITS-1:0] x,
                                        input logic [BASE_BITS-1:0] y);
    return (x <= BASE_T) && (y <= BASE_T) && (x[0] != y[0]);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic block_row_t close_block();
    block_row_t r;
    longint num, den, q;
    r.end_position = 32'(column_pos);
    r.abba_one = 24'(abba_one_n);
    r.baba_one = 24'(baba_one_n);
    r.abba_two = 24'(abba_two_n);
    r.baba_two = 24'(baba_two_n);
    r.zero_divisor = (abba_two_n == baba_two_n);
    r.f_hat = '0;
    if (!r.zero_divisor) begin
      num = longint'(abba_one_n) - longint'(baba_one_n);
      den = longint'(abba_two_n) - longint'(baba_two_n);
      q = ((num < 0 ? -num : num) <<< 16) / (den < 0 ? -den : den);
      if ((num < 0) != (den < 0)) begin
        if (q > RATIO_NEG_LIMIT) q = RATIO_NEG_LIMIT;
        r.f_hat = 32'(-q);
      end else begin
        if (q > RATIO_POS_LIMIT) q = RATIO_POS_LIMIT;
        r.f_hat = 32'(q);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    block_row_t got, want;
    logic [BASE_BITS-1:0] b1, b2, a, a2, o;
    if (rst) begin
      expected_rows.delete();
      cur_block_len = BLOCK_LEN_RESET;
      column_pos = '0;
      abba_one_n = '0;
      baba_one_n = '0;
      abba_two_n = '0;
      baba_two_n = '0;
    end else begin
      // Rows leaving at this edge belong to columns taken at earlier edges.
      if (out_valid && !out_stall) begin
        got = {end_position, f_hat, abba_one, baba_one, abba_two, baba_two, zero_divisor};
        if (expected_rows.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected row: pos %0d f_hat %0d counts %0d %0d %0d %0d zdiv %0b",
                     got.end_position, $signed(got.f_hat), got.abba_one, got.baba_one,
                     got.abba_two, got.baba_two, got.zero_divisor);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("row mismatch: expected pos %0d f_hat %0d counts %0d %0d %0d %0d zdiv %0b",
                       want.end_position, $signed(want.f_hat), want.abba_one, want.baba_one,
                       want.abba_two, want.baba_two, want.zero_divisor);
              $display("              actual   pos %0d f_hat %0d counts %0d %0d %0d %0d zdiv %0b",
                       got.end_position, $signed(got.f_hat), got.abba_one, got.baba_one,
                       got.abba_two, got.baba_two, got.zero_divisor);
            end
          end
        end
      end

      if (cfg_valid && cfg_ready)
        cur_block_len = block_len;

      if (in_valid && !in_stall) begin
        if (cmd == CMD_FLUSH) begin
          expected_rows.push_back(close_block());
          column_pos = '0;
          abba_one_n = '0;
          baba_one_n = '0;
          abba_two_n = '0;
          baba_two_n = '0;
        end else begin
          b1 = base_first;
          b2 = base_second;
          a  = base_admix;
          a2 = base_admix_two;
          o  = base_outgroup;
          column_pos = column_pos + 1'b1;
          if (b1 != BASE_N && b2 != BASE_N && a != BASE_N && a2 != BASE_N && o != BASE_N) begin
            if (b1 == o && b2 != o && b2 == a2 && crosses_ring(b1, b2))
              abba_one_n = sat_inc(abba_one_n);
            if (b1 != o && b2 == o && b1 == a2 && crosses_ring(b1, b2))
              baba_one_n = sat_inc(baba_one_n);
            if (b1 == o && a != o && a == a2 && crosses_ring(b1, a))
              abba_two_n = sat_inc(abba_two_n);
            if (b1 == a2 && a2 != o && a == o && crosses_ring(b1, a))
              baba_two_n = sat_inc(baba_two_n);
          end
          if (cur_block_len != 0 && column_pos % cur_block_len == 0) begin
            expected_rows.push_back(close_block());
            abba_one_n = '0;
            baba_one_n = '0;
            abba_two_n = '0;
            baba_two_n = '0;
          end
        end
      end
    end
    errors <= mismatch_cnt;
    rows_waiting <= expected_rows.size();
  end

endmodule

// ===== tb/tb_abba_baba_block_counter.sv =====
// Top of the ABBA/BABA block counter testbench: clock, reset, column and
// block length stimulus, row-side stalls and the verdict.
// Depends on abbc_pkg, abba_baba_block_counter and abbc_row_checker.

module tb_abba_baba_block_counter;
  import abbc_pkg::*;

  localparam logic [BASE_BITS-1:0]  BASE_OTHER     = 3'd5;
  localparam logic [BASE_BITS-1:0]  BASE_OTHER_MID = 3'd6;
  localparam logic [BASE_BITS-1:0]  BASE_OTHER_HI  = 3'd7;
  localparam logic [BLOCK_BITS-1:0] BLOCK_LEN_MAX  = '1;
  localparam int SETTLE_CYCLES = 60;
  localparam int SAT_RUN       = 20;
  localparam int ITEMS_PER_SET = 55;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [BLOCK_BITS-1:0] block_len = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_COLUMN;
  logic [BASE_BITS-1:0]  base_first = BASE_A;
  logic [BASE_BITS-1:0]  base_second = BASE_A;
  logic [BASE_BITS-1:0]  base_admix = BASE_A;
  logic [BASE_BITS-1:0]  base_admix_two = BASE_A;
  logic [BASE_BITS-1:0]  base_outgroup = BASE_A;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [31:0]           end_position;
  logic signed [31:0]    f_hat;
  logic [23:0]           abba_one, baba_one, abba_two, baba_two;
  logic                  zero_divisor;
  int                    errors, rows_waiting;
  int                    idle_pct = 0;
  int                    stall_pct = 0;

  abba_baba_block_counter dut (.*);
  abbc_row_checker row_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  task automatic send(input logic c, input logic [BASE_BITS-1:0] b1, b2, a, a2, o);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    base_first <= b1;
    base_second <= b2;
    base_admix <= a;
    base_admix_two <= a2;
    base_outgroup <= o;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every predicted row is out and the divider has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (rows_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_block_len(input logic [BLOCK_BITS-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    block_len <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BASE_BITS-1:0] any_code();
    return BASE_BITS'($urandom_range(BASE_OTHER_HI));
  endfunction

  function automatic logic [BASE_BITS-1:0] pick_acgt();
    return BASE_BITS'($urandom_range(BASE_T));
  endfunction

  // A transversion partner flips the purine/pyrimidine bit.
  function automatic logic [BASE_BITS-1:0] across(input logic [BASE_BITS-1:0] x);
    return x ^ ($urandom_range(1) ? 3'd1 : 3'd3);
  endfunction

  function automatic logic [BLOCK_BITS-1:0] pick_size(input int set_no);
    case (set_no)
      0: return BLOCK_BITS'(1);
      1: return BLOCK_BITS'($urandom_range(4, 2));
      2: return BLOCK_BITS'(0);
      3: return BLOCK_BITS'($urandom_range(20, 5));
      4: return BLOCK_BITS'(1);
      5: return BLOCK_BITS'($urandom_range(BLOCK_LEN_MAX));
      6: return BLOCK_BITS'($urandom_range(6, 2));
      default: return BLOCK_BITS'($urandom_range(12, 3));
    endcase
  endfunction

  // Mostly well-formed site patterns with random bases, plus noise.
  task automatic send_random();
    logic [BASE_BITS-1:0] x, y, b1, b2, a, a2, o;
    int roll;
    roll = $urandom_range(99);
    x = pick_acgt();
    y = across(x);
    b1 = pick_acgt();
    b2 = pick_acgt();
    a = pick_acgt();
    a2 = pick_acgt();
    o = pick_acgt();
    if (roll < 5) begin
      send(CMD_FLUSH, any_code(), any_code(), any_code(), any_code(), any_code());
    end else begin
      if (roll < 21) begin
        b1 = x; o = x; b2 = y; a2 = y;
      end else if (roll < 37) begin
        b1 = x; b2 = y; o = y; a2 = x;
      end else if (roll < 53) begin
        b1 = x; o = x; a = y; a2 = y;
      end else if (roll < 69) begin
        b1 = x; a2 = x; a = y; o = y;
      end else if (roll < 77) begin
        // Same shape as an ABBA site but the pair is a transition.
        b1 = x; o = x; b2 = x ^ 3'd2; a2 = x ^ 3'd2;
      end else if (roll < 85) begin
        b1 = x; o = x; b2 = y; a2 = y;
        case ($urandom_range(4))
          0: b1 = BASE_N;
          1: b2 = BASE_N;
          2: a = BASE_N;
          3: a2 = BASE_N;
          default: o = BASE_N;
        endcase
      end else if (roll < 93) begin
        b1 = any_code(); b2 = any_code(); a = any_code(); a2 = any_code(); o = any_code();
      end
      send(CMD_COLUMN, b1, b2, a, a2, o);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset block length: only scaffold ends emit here.
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_C, BASE_A);
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_A, BASE_C);
    send(CMD_COLUMN, BASE_G, BASE_G, BASE_T, BASE_T, BASE_G);
    send(CMD_COLUMN, BASE_T, BASE_T, BASE_G, BASE_T, BASE_G);
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_C, BASE_N);
    send(CMD_COLUMN, BASE_N, BASE_C, BASE_A, BASE_C, BASE_A);
    send(CMD_COLUMN, BASE_A, BASE_G, BASE_A, BASE_G, BASE_A);
    send(CMD_COLUMN, BASE_OTHER, BASE_OTHER_MID, BASE_OTHER, BASE_OTHER_MID, BASE_OTHER);
    send(CMD_COLUMN, BASE_OTHER_HI, BASE_OTHER_HI, BASE_OTHER_HI, BASE_OTHER_HI,
         BASE_OTHER_HI);
    send(CMD_COLUMN, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);
    send(CMD_FLUSH, BASE_OTHER_HI, BASE_OTHER_HI, BASE_OTHER_HI, BASE_OTHER_HI,
         BASE_OTHER_HI);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_C, BASE_A);
    send(CMD_COLUMN, BASE_C, BASE_G, BASE_C, BASE_G, BASE_C);
    send(CMD_COLUMN, BASE_T, BASE_T, BASE_G, BASE_T, BASE_G);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);

    // Every column closes a block, and a scaffold end still emits right after.
    set_block_len(1);
    send(CMD_COLUMN, BASE_G, BASE_G, BASE_T, BASE_T, BASE_G);
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_A, BASE_C);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);

    // Zero block length never closes a block.
    set_block_len(0);
    send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_C, BASE_A);
    send(CMD_COLUMN, BASE_T, BASE_T, BASE_G, BASE_T, BASE_G);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);

    // Runs against a single divisor site give large ratios of both signs.
    set_block_len(BLOCK_LEN_MAX);
    repeat (SAT_RUN) send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_C, BASE_A);
    send(CMD_COLUMN, BASE_A, BASE_A, BASE_C, BASE_C, BASE_A);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);
    repeat (SAT_RUN) send(CMD_COLUMN, BASE_A, BASE_C, BASE_A, BASE_A, BASE_C);
    send(CMD_COLUMN, BASE_A, BASE_A, BASE_C, BASE_C, BASE_A);
    send(CMD_FLUSH, BASE_A, BASE_A, BASE_A, BASE_A, BASE_A);

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 65; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int k = 0; k < 2; k++) begin
        set_block_len(pick_size(2 * mode + k));
        repeat (ITEMS_PER_SET) send_random();
      end
    end

    settle();
    if (errors == 0 && rows_waiting == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
